[sv/msg_pkg.sv]
// package: types, constants and codes shared by the speed governor files
package msg_pkg;

    localparam int NUM_SOURCES         = 4;
    localparam int ALERT_HOLDOFF_TICKS = 40;
    localparam int SRC_W               = 2;
    localparam logic [15:0] AGE_MAX    = 16'hFFFF;

    typedef enum logic [2:0] {
        K_TICK   = 3'd0,
        K_CMD    = 3'd1,
        K_LIMIT  = 3'd2,
        K_ODOM   = 3'd3,
        K_ENABLE = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        R_MASK    = 3'd0,
        R_TO0     = 3'd1,
        R_TO1     = 3'd2,
        R_TO2     = 3'd3,
        R_TO3     = 3'd4,
        R_THRESH  = 3'd5,
        R_CMD_TO  = 3'd6,
        R_DECEL   = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AGE,
        S_DECAY_L,
        S_DECAY_A,
        S_SRC,
        S_SAT,
        S_RESCALE,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // take the accepted word
        logic age;       // age counters, stale check
        logic div_lin;   // start decay of linear
        logic div_ang;   // start decay of angular
        logic src;       // clamp and filter one source
        logic sat;       // saturate linear, alert
        logic div_rsc;   // start rescale divide
        logic fin;       // capture result
        logic [SRC_W-1:0] idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic stale;     // command decay applies
        logic rescale;   // rescale divide needed
        logic div_busy;
    } t_stat;

endpackage

[sv/msg_if.sv]
// interfaces: valid/ready channels for items, results and configuration
interface msg_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [1:0]  source_index;
    logic signed [15:0] speed_value;
    logic signed [15:0] turn_rate;
    logic        enable_flag;
    modport source (output valid, kind, source_index, speed_value, turn_rate, enable_flag,
                    input ready);
    modport sink (input valid, kind, source_index, speed_value, turn_rate, enable_flag,
                  output ready);
endinterface

interface msg_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] linear_out;
    logic signed [15:0] angular_out;
    logic        vibrate_valid;
    logic [7:0]  vibrate_strength;
    modport source (output valid, linear_out, angular_out, vibrate_valid, vibrate_strength,
                    input ready);
    modport sink (input valid, linear_out, angular_out, vibrate_valid, vibrate_strength,
                  output ready);
endinterface

interface msg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/multi_source_speed_governor_top.sv]
// top level: multi-source speed governor
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    kind, source_index, speed_value, turn_rate, enable_flag
//  out_ch    out  valid/ready    linear_out, angular_out, vibrate_valid, vibrate_strength
//  cfg_ch    in   valid/ready    index (3), data (16)
//
//  a non-tick word only updates state; a tick runs up to three divides (linear decay,
//  angular decay, rescale) one after another on one shared bit-serial divider,
//  then waits for the result register
//  the result register holds one word; the next word is taken while it waits
//  reset is synchronous, active low, and restores the governor state and configuration registers at once
module multi_source_speed_governor_top
    import msg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    msg_in_if.sink    in_ch,
    msg_out_if.source out_ch,
    msg_cfg_if.sink   cfg_ch
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  r_out_valid;
    logic  w_out_free;

    // result register is free when empty or being drained
    assign w_out_free   = !r_out_valid || out_ch.ready;
    assign in_ch.ready  = w_in_ready;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_out_valid;

    msg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (in_ch.valid && w_in_ready),
        .i_out_free(w_out_free),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_in_ready(w_in_ready)
    );

    msg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (cfg_ch.valid),
        .i_cfg_index   (cfg_ch.index),
        .i_cfg_data    (cfg_ch.data),
        .i_kind        (in_ch.kind),
        .i_source_index(in_ch.source_index),
        .i_speed_value (in_ch.speed_value),
        .i_turn_rate   (in_ch.turn_rate),
        .i_enable_flag (in_ch.enable_flag),
        .o_linear      (out_ch.linear_out),
        .o_angular     (out_ch.angular_out),
        .o_vib_valid   (out_ch.vibrate_valid),
        .o_vib_strength(out_ch.vibrate_strength)
    );

    // result valid: set when a tick finishes, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // a result only appears after a finish command
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_cmd.fin))
        else $error("result valid without finish");

    // no vibration strength without vibration
    a_vib: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !out_ch.vibrate_valid |-> out_ch.vibrate_strength == 8'd0)
        else $error("strength without vibration");

    // input is never ready while the shared divider is busy
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_ready |-> !w_stat.div_busy)
        else $error("input ready while divider busy");
endmodule

[sv/msg_div.sv]
// divider: signed restoring division, one quotient bit per cycle, truncates toward zero
module msg_div
    import msg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic signed [32:0] i_num,
    input  logic signed [16:0] i_den,
    output logic        o_busy,
    output logic signed [32:0] o_quo
);
    logic [32:0] r_q, n_q;
    logic [17:0] r_rem, n_rem;
    logic [16:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic [17:0] w_trial;
    logic [32:0] w_anum;

    assign w_anum  = i_num[32] ? 33'(-i_num) : i_num;
    assign w_trial = {r_rem[16:0], r_q[32]} - {1'b0, r_den};
    assign o_busy  = (r_cnt != 6'd0);
    assign o_quo   = r_neg ? 33'(-$signed(r_q)) : $signed(r_q);

    always_comb begin
        n_rem = {r_rem[16:0], r_q[32]};
        n_q   = {r_q[31:0], 1'b0};
        if (!w_trial[17]) begin
            n_rem = w_trial;
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd33;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 6'd1;
        end
        if (i_start) begin
            r_q   <= w_anum;
            r_rem <= '0;
            r_den <= i_den[16] ? 17'(-i_den) : i_den;
            r_neg <= i_num[32] ^ i_den[16];
        end else if (o_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end
endmodule

[sv/msg_ctrl.sv]
// controller: steps each word; a tick runs aging, decay if stale, per-source pass, saturate, rescale if needed
module msg_ctrl
    import msg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_fire,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready
);
    t_state r_state, n_state;
    logic [SRC_W-1:0] r_idx, n_idx;
    logic r_go, n_go;   // divide launched in this state

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_go    = 1'b0;
        case (r_state)
            S_IDLE:    if (i_in_fire) n_state = S_AGE;
            S_AGE:     n_state = i_stat.is_tick
                               ? (i_stat.stale ? S_DECAY_L : S_SRC) : S_IDLE;
            S_DECAY_L: begin
                n_go = 1'b1;
                if (r_go && !i_stat.div_busy) begin
                    n_state = S_DECAY_A;
                    n_go = 1'b0;
                end
            end
            S_DECAY_A: begin
                n_go = 1'b1;
                if (r_go && !i_stat.div_busy) begin
                    n_state = S_SRC;
                    n_go = 1'b0;
                end
            end
            S_SRC: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == SRC_W'(NUM_SOURCES - 1)) begin
                    n_state = S_SAT;
                    n_idx = '0;
                end
            end
            S_SAT:     n_state = i_stat.rescale ? S_RESCALE : S_OUT;
            S_RESCALE: begin
                n_go = 1'b1;
                if (r_go && !i_stat.div_busy) begin
                    n_state = S_OUT;
                    n_go = 1'b0;
                end
            end
            S_OUT:     if (i_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.idx = r_idx;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE:    begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_fire;
            end
            S_AGE:     o_cmd.age = 1'b1;
            S_DECAY_L: o_cmd.div_lin = !r_go;
            S_DECAY_A: o_cmd.div_ang = !r_go;
            S_SRC:     o_cmd.src = 1'b1;
            S_SAT:     o_cmd.sat = 1'b1;
            S_RESCALE: o_cmd.div_rsc = !r_go;
            S_OUT:     o_cmd.fin = i_out_free;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_go    <= n_go;
        end
    end
endmodule

[sv/msg_dp.sv]
// datapath: governor state, configuration registers, per-source arithmetic, shared divider
module msg_dp
    import msg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_kind,
    input  logic [1:0]  i_source_index,
    input  logic signed [15:0] i_speed_value,
    input  logic signed [15:0] i_turn_rate,
    input  logic        i_enable_flag,
    output logic signed [15:0] o_linear,
    output logic signed [15:0] o_angular,
    output logic        o_vib_valid,
    output logic [7:0]  o_vib_strength
);
    // configuration
    logic [3:0]  r_mask;
    logic [15:0] r_timeout [NUM_SOURCES];
    logic [14:0] r_thresh;
    logic [15:0] r_cmd_to, r_decel;
    // state
    logic signed [15:0] r_limit [NUM_SOURCES];
    logic [15:0] r_age [NUM_SOURCES];
    logic signed [23:0] r_filt [NUM_SOURCES];
    logic [3:0]  r_en;
    logic signed [15:0] r_cl, r_ca;
    logic [15:0] r_cage, r_vage;
    logic [5:0]  r_alert;
    // working registers
    logic [2:0]  r_kind;
    logic [1:0]  r_sidx;
    logic signed [15:0] r_spd, r_trn;
    logic        r_flag;
    logic signed [17:0] r_l;
    logic signed [15:0] r_r, r_lsat;
    logic [15:0] r_keep, r_d;
    logic        r_vv;
    logic [7:0]  r_vs;
    // angular decay result waiting to be written back
    logic        r_decay_pend;
    // rescale divide ran for this tick
    logic        r_rsc_pend;

    logic        w_div_start, w_div_busy;
    logic signed [32:0] w_num, w_quo;
    logic signed [16:0] w_den;
    logic signed [32:0] r_prod;

    msg_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_busy (w_div_busy),
        .o_quo  (w_quo)
    );

    assign w_div_start = i_cmd.div_lin | i_cmd.div_ang | i_cmd.div_rsc;
    always_comb begin
        if (i_cmd.div_lin) begin
            w_num = 33'(r_cl) * $signed({17'd0, r_keep});
            w_den = $signed({1'b0, r_d});
        end else if (i_cmd.div_ang) begin
            w_num = 33'(r_ca) * $signed({17'd0, r_keep});
            w_den = $signed({1'b0, r_d});
        end else begin
            w_num = r_prod;
            w_den = 17'(r_cl);
        end
    end

    // tick aging and decay factor
    logic [15:0] w_cage_n;
    logic [15:0] w_over, w_d, w_m;
    assign w_cage_n = (r_cage != AGE_MAX) ? r_cage + 16'd1 : AGE_MAX;
    assign w_d      = (r_decel != 16'd0) ? r_decel : 16'd1;
    assign w_over   = w_cage_n - r_cmd_to;
    assign w_m      = (w_over < w_d) ? w_over : w_d;

    // one source
    logic signed [15:0] w_lim;
    logic signed [17:0] w_l1, w_l2, w_nlim;
    logic signed [29:0] w_fsum;
    logic [27:0] w_fy;
    logic [56:0] w_fprod;
    logic signed [25:0] w_fq;
    logic signed [23:0] w_fnew;
    assign w_lim  = r_limit[i_cmd.idx];
    assign w_nlim = -18'(w_lim);
    assign w_l1   = (18'(w_lim) < r_l) ? 18'(w_lim) : r_l;
    assign w_l2   = (w_l1 < w_nlim) ? w_nlim : w_l1;
    assign w_fsum = 30'(r_filt[i_cmd.idx]) * 30'sd9 + (30'(w_lim) <<< 8) + 30'sd5;
    // floor divide by ten: bias by ten times 2^24 so the sum is positive,
    // multiply by ceil(2^32 / 10) and keep the upper bits, then remove the bias
    assign w_fy    = 28'(w_fsum + 30'sd167772160);
    assign w_fprod = 57'(w_fy) * 57'(29'd429496730);
    assign w_fq    = $signed({1'b0, w_fprod[56:32]}) - 26'sd16777216;
    assign w_fnew  = (w_fq > 26'sd8388607) ? 24'sh7FFFFF :
                     (w_fq < -26'sd8388608) ? -24'sh800000 : 24'(w_fq);

    logic signed [15:0] w_sat;
    assign w_sat = (r_l > 18'sd32767) ? 16'sh7FFF :
                   (r_l < -18'sd32768) ? -16'sh8000 : 16'(r_l);

    assign o_stat.is_tick  = (t_kind'(r_kind) == K_TICK);
    assign o_stat.stale    = (w_cage_n > r_cmd_to);
    assign o_stat.rescale  = (r_cl != 16'sd0) && (w_sat != 16'sd0);
    assign o_stat.div_busy = w_div_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_thresh <= 15'd20;
            r_cmd_to <= 16'd20;
            r_decel  <= 16'd20;
            r_en     <= 4'hF;
            r_cl     <= '0;
            r_ca     <= '0;
            r_cage   <= AGE_MAX;
            r_vage   <= AGE_MAX;
            r_alert  <= '0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_timeout[i] <= '0;
                r_limit[i]   <= '0;
                r_age[i]     <= '0;
                r_filt[i]    <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_index))
                    R_MASK:   r_mask <= i_cfg_data[3:0];
                    R_TO0:    r_timeout[0] <= i_cfg_data;
                    R_TO1:    r_timeout[1] <= i_cfg_data;
                    R_TO2:    r_timeout[2] <= i_cfg_data;
                    R_TO3:    r_timeout[3] <= i_cfg_data;
                    R_THRESH: r_thresh <= i_cfg_data[14:0];
                    R_CMD_TO: r_cmd_to <= i_cfg_data;
                    R_DECEL:  r_decel <= i_cfg_data;
                    default:  r_mask <= r_mask;
                endcase
            end
            if (i_cmd.age) begin
                case (t_kind'(r_kind))
                    K_CMD: begin
                        r_cl <= r_spd;
                        r_ca <= r_trn;
                        r_cage <= '0;
                    end
                    K_LIMIT: begin
                        r_limit[r_sidx] <= r_spd;
                        r_age[r_sidx]   <= '0;
                    end
                    K_ODOM: if (r_spd > 16'sd1024 && r_cl > 16'sd0) r_alert <= r_spd[15:10];
                    K_ENABLE: r_en[r_sidx] <= r_flag;
                    K_TICK: begin
                        for (int i = 0; i < NUM_SOURCES; i++) begin
                            logic [15:0] a;
                            a = (r_age[i] != AGE_MAX) ? r_age[i] + 16'd1 : AGE_MAX;
                            r_age[i] <= a;
                            if (r_timeout[i] != 16'd0 && a > r_timeout[i]) r_limit[i] <= '0;
                        end
                        r_cage <= w_cage_n;
                        r_vage <= (r_vage != AGE_MAX) ? r_vage + 16'd1 : AGE_MAX;
                    end
                    default: r_cage <= r_cage;
                endcase
            end
            // linear decay result is taken when the angular divide starts
            if (i_cmd.div_ang) r_cl <= 16'(w_quo);
            // angular decay result is taken at the first source
            if (i_cmd.src && i_cmd.idx == '0 && r_decay_pend) r_ca <= 16'(w_quo);
            if (i_cmd.src && r_en[i_cmd.idx]) begin
                r_filt[i_cmd.idx] <= w_fnew;
            end
            if (i_cmd.sat && w_sat == 16'sd0 && r_alert != 6'd0) begin
                if (r_vage > 16'(ALERT_HOLDOFF_TICKS)) r_vage <= '0;
                r_alert <= '0;
            end
        end
    end

    // angular decay result is written back when the pass over sources begins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_pend <= 1'b0;
        end else if (i_cmd.div_ang) begin
            r_decay_pend <= 1'b1;
        end else if (i_cmd.src) begin
            r_decay_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_sidx <= i_source_index;
            r_spd  <= i_speed_value;
            r_trn  <= i_turn_rate;
            r_flag <= i_enable_flag;
        end
        if (i_cmd.age) begin
            r_keep <= w_d - w_m;
            r_d    <= w_d;
            r_l    <= 18'(r_cl);
            r_r    <= r_ca;
        end
        if (i_cmd.div_ang) begin
            r_l <= 18'(w_quo);
        end
        if (i_cmd.src) begin
            if (i_cmd.idx == '0 && r_decay_pend) begin
                r_r <= 16'(w_quo);
            end
            if (r_en[i_cmd.idx]) begin
                r_l <= w_l2;
                if (w_lim == 16'sd0 && (r_mask[i_cmd.idx]
                        || $signed({9'd0, r_thresh, 8'd0}) < 32'(w_fnew)))
                    r_r <= '0;
            end
        end
        if (i_cmd.sat) begin
            r_lsat <= w_sat;
            r_prod <= 33'(r_r) * 33'(w_sat);
            r_vv   <= 1'b0;
            r_vs   <= '0;
            if (w_sat == 16'sd0 && r_alert != 6'd0 && r_vage > 16'(ALERT_HOLDOFF_TICKS)) begin
                r_vv <= 1'b1;
                r_vs <= (r_alert > 6'd25) ? 8'd255 : 8'(r_alert) * 8'd10;
            end
        end
        if (i_cmd.fin) begin
            o_linear       <= r_lsat;
            o_angular      <= r_rsc_pend ? ((w_quo > 33'sd32767) ? 16'sh7FFF :
                              (w_quo < -33'sd32768) ? -16'sh8000 : 16'(w_quo)) : r_r;
            o_vib_valid    <= r_vv;
            o_vib_strength <= r_vs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sat) r_rsc_pend <= o_stat.rescale;
    end
endmodule

[bench/msg_tb_if.sv]
// testbench-side types: expected output word and directed stimulus row
package msg_tb_pkg;
    import msg_pkg::*;

    // one expected output word of the governor
    typedef struct {
        logic signed [15:0] linear;
        logic signed [15:0] angular;
        logic               vib_valid;
        logic [7:0]         vib_strength;
    } t_gov_out;

    // one row of the directed stimulus table
    typedef struct {
        logic [2:0]         kind;
        logic [1:0]         src;
        logic signed [15:0] speed;
        logic signed [15:0] turn;
        logic               flag;
        logic               typed;    // expected result given in the row
        logic signed [15:0] exp_lin;
        logic signed [15:0] exp_ang;
    } t_row;
endpackage

[bench/multi_source_speed_governor_top_test.sv]
// testbench for the multi-source speed governor: directed table, then random items
module multi_source_speed_governor_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import msg_pkg::*;
    import msg_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int N_RANDOM       = 650;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    msg_in_if  in_ch();
    msg_out_if out_ch();
    msg_cfg_if cfg_ch();

    multi_source_speed_governor_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // shadow copy of the governor: registers and state
    // ---------------------------------------------------------------
    logic [3:0]  gov_stop_mask;
    logic [15:0] gov_src_timeout [NUM_SOURCES];
    logic [14:0] gov_threshold;
    logic [15:0] gov_cmd_timeout;
    logic [15:0] gov_decel;

    logic signed [15:0] gov_limit [NUM_SOURCES];
    logic [15:0]        gov_src_age [NUM_SOURCES];
    logic signed [23:0] gov_filt [NUM_SOURCES];
    logic [3:0]         gov_enabled;
    logic signed [15:0] gov_cmd_lin;
    logic signed [15:0] gov_cmd_ang;
    logic [15:0]        gov_cmd_age;
    logic [5:0]         gov_alert;
    logic [15:0]        gov_vib_age;

    t_gov_out expected_words[$];

    int mismatches = 0;
    int words_seen = 0;
    int items_sent = 0;
    int vibrations = 0;
    int idle_cycles = 0;
    bit no_idle = 0;

    function automatic logic [15:0] age_step(logic [15:0] a);
        return (a == AGE_MAX) ? a : a + 16'd1;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    task automatic governor_reset_state();
        gov_stop_mask = '0;
        gov_threshold = 15'd20;
        gov_cmd_timeout = 16'd20;
        gov_decel = 16'd20;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            gov_src_timeout[i] = '0;
            gov_limit[i] = '0;
            gov_src_age[i] = '0;
            gov_filt[i] = '0;
        end
        gov_enabled = 4'hF;
        gov_cmd_lin = '0;
        gov_cmd_ang = '0;
        gov_cmd_age = AGE_MAX;
        gov_alert = '0;
        gov_vib_age = AGE_MAX;
    endtask

    task automatic governor_write_reg(logic [2:0] idx, logic [15:0] val);
        case (t_reg'(idx))
            R_MASK:   gov_stop_mask = val[3:0];
            R_TO0:    gov_src_timeout[0] = val;
            R_TO1:    gov_src_timeout[1] = val;
            R_TO2:    gov_src_timeout[2] = val;
            R_TO3:    gov_src_timeout[3] = val;
            R_THRESH: gov_threshold = val[14:0];
            R_CMD_TO: gov_cmd_timeout = val;
            R_DECEL:  gov_decel = val;
            default: ;
        endcase
    endtask

    // advance the shadow on one accepted word; returns 1 with a result on a tick
    function automatic bit governor_step(logic [2:0] kind, logic [1:0] src,
                                         logic signed [15:0] speed,
                                         logic signed [15:0] turn, logic flag,
                                         output t_gov_out res);
        longint l, r, lim, f, d, over, m, ang;
        res = '{default: '0};
        case (kind)
            K_CMD: begin
                gov_cmd_lin = speed;
                gov_cmd_ang = turn;
                gov_cmd_age = '0;
                return 0;
            end
            K_LIMIT: begin
                gov_limit[src] = speed;
                gov_src_age[src] = '0;
                return 0;
            end
            K_ODOM: begin
                if (speed > 1024 && gov_cmd_lin > 0) gov_alert = speed[15:10];
                return 0;
            end
            K_ENABLE: begin
                gov_enabled[src] = flag;
                return 0;
            end
            K_TICK: ;
            default: return 0;
        endcase

        for (int i = 0; i < NUM_SOURCES; i++) begin
            gov_src_age[i] = age_step(gov_src_age[i]);
            if (gov_src_timeout[i] != 0 && gov_src_age[i] > gov_src_timeout[i])
                gov_limit[i] = '0;
        end
        gov_cmd_age = age_step(gov_cmd_age);
        gov_vib_age = age_step(gov_vib_age);

        // stale command decays, compounding every tick
        if (gov_cmd_age > gov_cmd_timeout) begin
            d = (gov_decel == 0) ? 64'sd1 : longint'(gov_decel);
            over = longint'(gov_cmd_age) - longint'(gov_cmd_timeout);
            m = (over < d) ? over : d;
            gov_cmd_lin = 16'((longint'(gov_cmd_lin) * (d - m)) / d);
            gov_cmd_ang = 16'((longint'(gov_cmd_ang) * (d - m)) / d);
        end

        l = longint'(gov_cmd_lin);
        r = longint'(gov_cmd_ang);
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (!gov_enabled[i]) continue;
            lim = longint'(gov_limit[i]);
            if (lim < l) l = lim;
            if (l < -lim) l = -lim;
            f = 9 * longint'(gov_filt[i]) + lim * 256 + 5;
            // floor division by ten
            if (f < 0 && (f % 10) != 0) f = f / 10 - 1;
            else f = f / 10;
            if (f > 8388607) f = 8388607;
            if (f < -8388608) f = -8388608;
            gov_filt[i] = f[23:0];
            if (lim == 0) begin
                if (gov_stop_mask[i]) r = 0;
                else if (longint'(gov_threshold) * 256 < f) r = 0;
            end
        end
        l = longint'(clip16(l));

        if (l == 0 && gov_alert > 0) begin
            if (gov_vib_age > ALERT_HOLDOFF_TICKS) begin
                res.vib_valid = 1'b1;
                res.vib_strength = (gov_alert * 10 > 255) ? 8'd255 : 8'(gov_alert * 10);
                gov_vib_age = '0;
            end
            gov_alert = '0;
        end

        if (gov_cmd_lin != 0 && l != 0) ang = clip16((r * l) / longint'(gov_cmd_lin));
        else ang = r;
        res.linear = l[15:0];
        res.angular = ang[15:0];
        return 1;
    endfunction

    // ---------------------------------------------------------------
    // driving: all inputs change at the falling edge
    // ---------------------------------------------------------------
    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = '0;
        in_ch.source_index = '0;
        in_ch.speed_value = '0;
        in_ch.turn_rate = '0;
        in_ch.enable_flag = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
    end

    // random idle bursts on the sender side, none near the end
    task automatic sender_gap();
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    // push one word, wait for acceptance, then update the shadow
    // valid stays up at the next falling edge; the next word or a drain replaces it
    task automatic send_word(logic [2:0] kind, logic [1:0] src, logic signed [15:0] speed,
                             logic signed [15:0] turn, logic flag, output t_gov_out res,
                             output bit has_res);
        sender_gap();
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.source_index <= src;
        in_ch.speed_value <= speed;
        in_ch.turn_rate <= turn;
        in_ch.enable_flag <= flag;
        do @(posedge i_clk); while (!in_ch.ready);
        has_res = governor_step(kind, src, speed, turn, flag, res);
        if (has_res) expected_words = {expected_words, res};
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        // a non-tick word leaves no result; let it settle
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // valid stays up at the next falling edge; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        governor_write_reg(idx, val);
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // result side: random stall bursts, checking at the rising edge
    // ---------------------------------------------------------------
    initial begin
        int stall;
        stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 5) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_gov_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            words_seen++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word lin=%0d ang=%0d",
                             out_ch.linear_out, out_ch.angular_out);
            end else begin
                want = expected_words.pop_front();
                if (out_ch.vibrate_valid) vibrations++;
                if (out_ch.linear_out !== want.linear || out_ch.angular_out !== want.angular ||
                    out_ch.vibrate_valid !== want.vib_valid ||
                    out_ch.vibrate_strength !== want.vib_strength) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: exp lin=%0d ang=%0d vib=%0b/%0d",
                                 words_seen, want.linear, want.angular, want.vib_valid,
                                 want.vib_strength,
                                 " got lin=%0d ang=%0d vib=%0b/%0d",
                                 out_ch.linear_out, out_ch.angular_out,
                                 out_ch.vibrate_valid, out_ch.vibrate_strength);
                end
            end
        end
    end

    // watchdog: cycles with nothing moving on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else if (in_ch.valid || cfg_ch.valid || expected_words.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // directed table: typed results only where obvious
    // ---------------------------------------------------------------
    t_row directed_rows[] = '{
        // tick straight after reset: nothing commanded, all zero
        '{K_TICK,   2'd0, 16'sd0,      16'sd0,      1'b0, 1'b1, 16'sd0, 16'sd0},
        // limits at the positive extreme
        '{K_LIMIT,  2'd0, 16'sh7FFF,   16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_LIMIT,  2'd1, 16'sh7FFF,   16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_LIMIT,  2'd2, 16'sh7FFF,   16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_LIMIT,  2'd3, 16'sh7FFF,   16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        // full forward command, no clamp with max limits
        '{K_CMD,    2'd0, 16'sh7FFF,   16'sh7FFF,   1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_TICK,   2'd0, 16'sd0,      16'sd0,      1'b0, 1'b1, 16'sh7FFF, 16'sh7FFF},
        '{K_CMD,    2'd0, 16'sh8000,   16'sh8000,   1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_TICK,   2'd0, 16'sd0,      16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        // most negative limit: the clamp reaches +32768 and saturates
        '{K_LIMIT,  2'd2, 16'sh8000,   16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_CMD,    2'd0, 16'sh7FFF,   16'sh1000,   1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_TICK,   2'd0, 16'sd0,      16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        // disable and re-enable a source
        '{K_ENABLE, 2'd2, 16'sd0,      16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_LIMIT,  2'd1, 16'sd0,      16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        // alert from odometry, then stop with zero limit
        '{K_ODOM,   2'd0, 16'sh7FFF,   16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_TICK,   2'd0, 16'sd0,      16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_ODOM,   2'd0, 16'sd1025,   16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_TICK,   2'd0, 16'sd0,      16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_ENABLE, 2'd2, 16'sd0,      16'sd0,      1'b1, 1'b0, 16'sd0, 16'sd0},
        '{K_ENABLE, 2'd1, 16'sd0,      16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0},
        // unknown kinds are dropped
        '{3'd5,     2'd3, 16'sh5555,   16'shAAAA,   1'b1, 1'b0, 16'sd0, 16'sd0},
        '{3'd7,     2'd0, 16'shAAAA,   16'sh5555,   1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_CMD,    2'd0, -16'sd4096,  16'sd300,    1'b0, 1'b0, 16'sd0, 16'sd0},
        '{K_TICK,   2'd0, 16'sd0,      16'sd0,      1'b0, 1'b0, 16'sd0, 16'sd0}
    };

    // random word, mostly well formed with a bias toward ticks
    task automatic random_word(output logic [2:0] kind, output logic [1:0] src,
                               output logic signed [15:0] speed,
                               output logic signed [15:0] turn, output logic flag);
        int pick;
        pick = $urandom_range(0, 99);
        src = 2'($urandom_range(0, 3));
        flag = ($urandom_range(0, 4) != 0);
        turn = 16'($urandom());
        speed = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                16'($signed($urandom_range(0, 8192)) - 4096);
        if (pick < 45) kind = K_TICK;
        else if (pick < 60) kind = K_CMD;
        else if (pick < 75) begin
            kind = K_LIMIT;
            // zero limits trigger the stop and alert paths
            if ($urandom_range(0, 3) == 0) speed = '0;
        end else if (pick < 87) kind = K_ODOM;
        else if (pick < 97) kind = K_ENABLE;
        else kind = 3'($urandom_range(5, 7));
    endtask

    task automatic random_phase(int count);
        logic [2:0] kind;
        logic [1:0] src;
        logic signed [15:0] speed, turn;
        logic flag;
        t_gov_out res;
        bit has_res;
        for (int n = 0; n < count; n++) begin
            random_word(kind, src, speed, turn, flag);
            send_word(kind, src, speed, turn, flag, res, has_res);
        end
    endtask

    initial begin
        t_gov_out res;
        bit has_res;
        int phase_items;
        governor_reset_state();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].kind, directed_rows[k].src, directed_rows[k].speed,
                      directed_rows[k].turn, directed_rows[k].flag, res, has_res);
            if (directed_rows[k].typed && has_res &&
                (res.linear !== directed_rows[k].exp_lin ||
                 res.angular !== directed_rows[k].exp_ang)) begin
                // shadow and table disagree: count it like a mismatch
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: exp lin=%0d ang=%0d shadow lin=%0d ang=%0d",
                             k, directed_rows[k].exp_lin, directed_rows[k].exp_ang,
                             res.linear, res.angular);
            end
        end
        drain_block();

        // several register settings, extremes included; every register written
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(R_MASK, 16'h000F);
                    write_reg(R_TO0, 16'd0);
                    write_reg(R_TO1, 16'd3);
                    write_reg(R_TO2, 16'd10);
                    write_reg(R_TO3, 16'hFFFF);
                    write_reg(R_THRESH, 16'h7FFF);
                    write_reg(R_CMD_TO, 16'd0);
                    write_reg(R_DECEL, 16'd1);
                end
                1: begin
                    write_reg(R_MASK, 16'h0000);
                    write_reg(R_THRESH, 16'd0);
                    write_reg(R_CMD_TO, 16'd5);
                    write_reg(R_DECEL, 16'd0);
                end
                2: begin
                    write_reg(R_MASK, 16'h0005);
                    write_reg(R_TO0, 16'd7);
                    write_reg(R_TO1, 16'd0);
                    write_reg(R_THRESH, 16'd20);
                    write_reg(R_CMD_TO, 16'hFFFF);
                    write_reg(R_DECEL, 16'hFFFF);
                end
                3: begin
                    write_reg(3'($urandom_range(0, 7)), 16'($urandom()));
                    write_reg(R_CMD_TO, 16'($urandom_range(0, 30)));
                    write_reg(R_DECEL, 16'($urandom_range(1, 40)));
                    write_reg(R_THRESH, 16'($urandom_range(0, 4000)));
                end
                default: begin
                    write_reg(R_MASK, 16'($urandom_range(0, 15)));
                    write_reg(R_TO2, 16'd0);
                    write_reg(R_CMD_TO, 16'd20);
                    write_reg(R_DECEL, 16'd20);
                    // last stretch with no idling on either side
                    no_idle = 1;
                end
            endcase
            cfg_ch.valid <= 1'b0;
            phase_items = N_RANDOM / 5;
            random_phase(phase_items);
            drain_block();
        end

        $display("run covered %0d words in, %0d results checked, %0d vibrations, 5 settings",
                 items_sent, words_seen, vibrations);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     expected_words.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
